[rtl/core/twp_pkg.sv]
// Package for the track phi window block: payload types, datapath widths
// and the arctangent table that the CORDIC stages use. No dependencies.
`default_nettype none

package twp_pkg;

    localparam int unsigned SQRT_STEPS   = 32;
    localparam int unsigned ATAN_ENTRIES = 24;
    localparam int unsigned SQRT_SHIFT   = 24;

    typedef logic signed [19:0] t_coord;
    typedef logic        [18:0] t_radius;
    typedef logic        [39:0] t_sq40;
    typedef logic        [63:0] t_root;
    typedef logic signed [35:0] t_vec;
    typedef logic signed [32:0] t_ang;

    typedef struct packed {
        t_coord  hit_x;
        t_coord  hit_y;
        t_radius layer_radius;
    } t_hit;

    typedef struct packed {
        logic [15:0] phi_window;
        logic        invalid;
    } t_result;

    // atan(2^-i) in units of pi/2^31, rounded to nearest.
    localparam t_ang ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

endpackage

`default_nettype wire

[rtl/core/twp_stream_if.sv]
// Valid/ready stream interface with a typed payload.
// Used by track_phi_window; the payload type comes from twp_pkg.
`default_nettype none

interface twp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/track_phi_window.sv]
// Top level of the track phi window block: squares, two pipelined square
// roots, a pipelined CORDIC and rounding. Depends on twp_pkg and twp_stream_if.
`default_nettype none

// One hit enters per clock and one result leaves per clock while the output
// register is not held. The stages are the input, square and setup
// registers, 32 square-root stages (one result bit each), one CORDIC stage
// per iteration (at most ATAN_ENTRIES) and the output register. The whole
// pipeline moves as one and holds only while the output register is full
// and not taken; empty slots do not collapse, so a stall holds every stage.
module track_phi_window #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    twp_stream_if.sink   i_hit,
    twp_stream_if.source o_win
);
    import twp_pkg::*;

    localparam int SQ = SQRT_STEPS;
    localparam int NI = (ANGLE_ITERATIONS < ATAN_ENTRIES) ? ANGLE_ITERATIONS : ATAN_ENTRIES;
    localparam int NV = 3 + SQ + NI;

    logic w_en;
    logic [NV-1:0] r_vld;
    logic          r_ovld;

    t_coord  r_a, r_b;
    t_radius r_r;
    t_sq40   r_aa, r_bb, r_rr;

    t_root r_rem_x [0:SQ];
    t_root r_res_x [0:SQ];
    t_root r_rem_y [0:SQ];
    t_root r_res_y [0:SQ];
    logic  r_inv   [0:SQ+NI];

    t_vec r_cx [0:NI];
    t_vec r_cy [0:NI];
    t_ang r_cz [0:NI];

    t_result r_out;

    t_sq40 n_s;
    logic  n_inv;

    assign w_en        = !r_ovld || o_win.ready;
    assign i_hit.ready = w_en;
    assign o_win.valid = r_ovld;
    assign o_win.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[NV-2:0], i_hit.valid};
            r_ovld <= r_vld[NV-1];
        end
    end

    always_comb begin
        n_s   = r_aa + r_bb;
        n_inv = (n_s == '0) || (r_rr < n_s);
    end

    // Input register, squares, then the setup of both root operands.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a        <= i_hit.data.hit_x;
            r_b        <= i_hit.data.hit_y;
            r_r        <= i_hit.data.layer_radius;
            r_aa       <= t_sq40'(r_a * r_a);
            r_bb       <= t_sq40'(r_b * r_b);
            r_rr       <= t_sq40'({21'd0, r_r} * {21'd0, r_r});
            r_inv[0]   <= n_inv;
            r_rem_x[0] <= {n_s[39:0], 24'd0};
            r_rem_y[0] <= {t_sq40'(r_rr - n_s), 24'd0};
            r_res_x[0] <= '0;
            r_res_y[0] <= '0;
        end
    end

    // Digit-by-digit square root, one result bit per stage.
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam t_root BIT = t_root'(1) << (62 - 2 * k);
        t_root n_rem_x, n_res_x, n_rem_y, n_res_y;

        always_comb begin
            if (r_rem_x[k] >= r_res_x[k] + BIT) begin
                n_rem_x = r_rem_x[k] - (r_res_x[k] + BIT);
                n_res_x = (r_res_x[k] >> 1) + BIT;
            end else begin
                n_rem_x = r_rem_x[k];
                n_res_x = r_res_x[k] >> 1;
            end
            if (r_rem_y[k] >= r_res_y[k] + BIT) begin
                n_rem_y = r_rem_y[k] - (r_res_y[k] + BIT);
                n_res_y = (r_res_y[k] >> 1) + BIT;
            end else begin
                n_rem_y = r_rem_y[k];
                n_res_y = r_res_y[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem_x[k+1] <= n_rem_x;
                r_res_x[k+1] <= n_res_x;
                r_rem_y[k+1] <= n_rem_y;
                r_res_y[k+1] <= n_res_y;
                r_inv[k+1]   <= r_inv[k];
            end
        end
    end

    assign r_cx[0] = t_vec'({4'd0, r_res_x[SQ][31:0]});
    assign r_cy[0] = t_vec'({4'd0, r_res_y[SQ][31:0]});
    assign r_cz[0] = '0;

    // Vectoring CORDIC: drives y toward zero and sums the angle.
    for (genvar i = 0; i < NI; i++) begin : g_cordic
        t_vec n_x, n_y;
        t_ang n_z;

        always_comb begin
            if (!r_cy[i][$bits(t_vec)-1]) begin
                n_x = r_cx[i] + (r_cy[i] >>> i);
                n_y = r_cy[i] - (r_cx[i] >>> i);
                n_z = r_cz[i] + ATAN_TABLE[i];
            end else begin
                n_x = r_cx[i] - (r_cy[i] >>> i);
                n_y = r_cy[i] + (r_cx[i] >>> i);
                n_z = r_cz[i] - ATAN_TABLE[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cx[i+1]       <= n_x;
                r_cy[i+1]       <= n_y;
                r_cz[i+1]       <= n_z;
                r_inv[SQ+i+1]   <= r_inv[SQ+i];
            end
        end
    end

    // Round pi/2^31 units to pi/65536 units and clamp to a quarter turn.
    t_ang        n_zc;
    logic [33:0] n_t;
    logic [15:0] n_phi;

    always_comb begin
        n_zc = r_cz[NI][$bits(t_ang)-1] ? '0 : r_cz[NI];
        n_t  = ({1'b0, n_zc} + 34'd16384) >> 15;
        if (n_t > 34'd32768) begin
            n_phi = 16'd32768;
        end else begin
            n_phi = n_t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.invalid    <= r_inv[SQ+NI];
            r_out.phi_window <= r_inv[SQ+NI] ? 16'd0 : n_phi;
        end
    end

endmodule

`default_nettype wire

[tb/twp_checker.sv]
// Result checker for track_phi_window: watches the hit and window channels,
// computes the expected phi window per hit and compares. Depends on twp_pkg.
`timescale 1ns / 100ps

module twp_checker #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_hit_valid,
    input  wire                  i_hit_ready,
    input  twp_pkg::t_hit        i_hit_data,
    input  wire                  i_win_valid,
    input  wire                  i_win_ready,
    input  twp_pkg::t_result     i_win_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_invalids
);
    import twp_pkg::*;

    t_result window_queue[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_val;
        res = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > v) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (v >= res + bit_val) begin
                v = v - (res + bit_val);
                res = (res >> 1) + bit_val;
            end else begin
                res = res >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return res;
    endfunction

    function automatic t_result predict_window(t_hit h);
        t_result   res;
        longint    hx;
        longint    hy;
        longint    rr;
        longint    sum_sq;
        longint    rad_sq;
        longint    vx;
        longint    vy;
        longint    ang;
        longint    dx;
        longint    dy;
        res = '0;
        hx = longint'(h.hit_x);
        hy = longint'(h.hit_y);
        rr = longint'({1'b0, h.layer_radius});
        sum_sq = hx * hx + hy * hy;
        rad_sq = rr * rr;
        if (sum_sq == 0 || rad_sq < sum_sq) begin
            res.invalid = 1'b1;
            return res;
        end
        vx = longint'(int_sqrt(64'(sum_sq) << SQRT_SHIFT));
        vy = longint'(int_sqrt(64'(rad_sq - sum_sq) << SQRT_SHIFT));
        ang = 0;
        for (int i = 0; i < ANGLE_ITERATIONS && i < ATAN_ENTRIES; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx;
                vy -= dy;
                ang += longint'(ATAN_TABLE[i]);
            end else begin
                vx -= dx;
                vy += dy;
                ang -= longint'(ATAN_TABLE[i]);
            end
        end
        if (ang < 0) ang = 0;
        ang = (ang + 16384) >>> 15;
        if (ang > 32768) ang = 32768;
        res.phi_window = ang[15:0];
        return res;
    endfunction

    assign o_pending = window_queue.size();

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            o_errors   <= 0;
            o_results  <= 0;
            o_invalids <= 0;
        end else begin
            if (i_hit_valid && i_hit_ready)
                window_queue = {window_queue, predict_window(i_hit_data)};
            if (i_win_valid && i_win_ready) begin
                o_results <= o_results + 1;
                if (i_win_data.invalid) o_invalids <= o_invalids + 1;
                if (window_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %0d/%0b",
                        i_win_data.phi_window, i_win_data.invalid);
                    o_errors <= o_errors + 1;
                end else begin
                    want = window_queue.pop_front();
                    if (want !== i_win_data) begin
                        if (o_errors < 10)
                            $display("mismatch: expected window %0d invalid %0b, got %0d %0b",
                                want.phi_window, want.invalid,
                                i_win_data.phi_window, i_win_data.invalid);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_track_phi_window.sv]
// Testbench top for track_phi_window: drives hits with bursty timing and a
// stalling receiver, and reports the verdict. Depends on twp_pkg, twp_stream_if
// and twp_checker.
`timescale 1ns / 100ps

module tb_track_phi_window;
    import twp_pkg::*;

    localparam int ITERS   = 16;
    localparam int LATENCY = 35 + ITERS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   results;
    int   invalids;
    logic long_hold = 1'b0;
    int   sent = 0;

    twp_stream_if #(.T(t_hit))    hit_if ();
    twp_stream_if #(.T(t_result)) win_if ();

    always #2 i_clk = ~i_clk;

    track_phi_window #(.ANGLE_ITERATIONS(ITERS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hit   (hit_if.sink),
        .o_win   (win_if.source)
    );

    twp_checker #(.ANGLE_ITERATIONS(ITERS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hit_valid (hit_if.valid),
        .i_hit_ready (hit_if.ready),
        .i_hit_data  (hit_if.data),
        .i_win_valid (win_if.valid),
        .i_win_ready (win_if.ready),
        .i_win_data  (win_if.data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_invalids  (invalids)
    );

    initial begin
        hit_if.valid = 1'b0;
        hit_if.data  = '0;
        win_if.ready = 1'b0;
    end

    // Receiver: own stall pattern, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (long_hold) win_if.ready <= 1'b0;
        else if (sent < 300) win_if.ready <= 1'b1;
        else win_if.ready <= ($urandom_range(0, 9) < 7);
    end

    task automatic send_hit(input t_hit h);
        hit_if.data  <= h;
        hit_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!hit_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_gap();
        hit_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    function automatic t_hit random_hit();
        t_hit h;
        int   mode;
        int   lim;
        mode = $urandom_range(0, 9);
        h.layer_radius = t_radius'($urandom);
        if (mode < 6) begin
            // Valid geometry: keep the hit inside a circle of the radius.
            lim = int'(h.layer_radius) * 7 / 10;
            h.hit_x = t_coord'($signed($urandom_range(0, 2 * lim)) - lim);
            h.hit_y = t_coord'($signed($urandom_range(0, 2 * lim)) - lim);
        end else if (mode < 8) begin
            h.layer_radius = t_radius'($urandom_range(0, 4000));
            h.hit_x = t_coord'($signed($urandom_range(0, 6000)) - 3000);
            h.hit_y = t_coord'($signed($urandom_range(0, 6000)) - 3000);
        end else begin
            h.hit_x = t_coord'($urandom);
            h.hit_y = t_coord'($urandom);
        end
        return h;
    endfunction

    function automatic t_hit mk(int x, int y, int r);
        t_hit h;
        h.hit_x = t_coord'(x);
        h.hit_y = t_coord'(y);
        h.layer_radius = t_radius'(r);
        return h;
    endfunction

    initial begin
        int burst;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: origin, outside, on the layer, extremes, all quadrants.
        send_hit(mk(0, 0, 1000));
        send_hit(mk(0, 0, 0));
        send_hit(mk(2000, 0, 1000));
        send_hit(mk(1000, 0, 1000));
        send_hit(mk(0, -1000, 1000));
        send_hit(mk(300, 400, 500));
        send_hit(mk(-524288, -524288, 524287));
        send_hit(mk(524287, 524287, 524287));
        send_hit(mk(-524288, 0, 524287));
        send_hit(mk(524287, 0, 524287));
        send_hit(mk(0, 524287, 524287));
        send_hit(mk(1, 0, 524287));
        send_hit(mk(0, -1, 524287));
        send_hit(mk(-1, -1, 2));
        send_hit(mk(1, 1, 1));
        send_hit(mk(-370727, 370727, 524287));
        send_hit(mk(100, -100, 142));
        send_hit(mk(-5000, 3000, 6000));
        send_hit(mk(3, 4, 5));
        send_hit(mk(-3, -4, 6));

        // Sender pauses until every expected result is back.
        hit_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Fill the pipeline against a long receiver hold-off.
        long_hold <= 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(negedge i_clk);
                long_hold <= 1'b0;
            end
            repeat (150) send_hit(random_hit());
        join

        while (sent < 1620) begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_hit(random_hit());
            if ($urandom_range(0, 3) != 0) send_gap();
        end
        hit_if.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Sent %0d hits; %0d results checked, %0d flagged invalid.",
            sent, results, invalids);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
